FILE: hdl/gwn_pkg.sv
// shared types, codes and sizes of the grid window nearest-node search
`timescale 1ns / 1ps
`default_nettype none

package gwn_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int MAX_RADIUS = 15;

  localparam int COORD_W    = 6;
  localparam int RIN_W      = 4;
  localparam int OUT_DIST_W = 5;
  localparam int CELL_W     = 2;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int GRID_W = $clog2(GRID_SIDE);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int DIST_W = RAD_W + 1;
  localparam int BASE_W = (COORD_W > GRID_W) ? COORD_W : GRID_W;
  localparam int POS_W  = ((BASE_W > RAD_W + 1) ? BASE_W : RAD_W + 1) + 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [CELL_W-1:0] {
    CELL_EMPTY = 2'd0,
    CELL_FOOD  = 2'd1,
    CELL_FISH  = 2'd2
  } cell_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic               clear;
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIST_W-1:0]  distance;
  } probe_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIST_W-1:0]  distance;
  } best_t;

  typedef struct packed {
    logic                  found;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic                  kind;
    logic [OUT_DIST_W-1:0] distance;
  } pick_t;

endpackage

`default_nettype wire

FILE: hdl/grid_window_nearest_two_class_core.sv
// top level of the grid window nearest fish/food search
//
// a beat is taken on start while busy is low. update writes the store and
// leaves busy low. clear, and reset, run a sweep over the store of
// GRID_SIDE*GRID_SIDE cells (4096) with busy high, one cell written per
// cycle. a query of saturated radius r scans a (2r+1)^2 window with busy
// high: the single read port of the store gives one window cell per
// cycle, then the drain state finishes the last compare and the result
// is shown with done for one cycle, the last busy cycle. the receiver
// cannot stall, so the result must be taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module grid_window_nearest_two_class_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [1:0]                     command,
  input  wire logic [gwn_pkg::COORD_W-1:0]    cell_x,
  input  wire logic [gwn_pkg::COORD_W-1:0]    cell_y,
  input  wire logic                           node_kind,
  input  wire logic                           has_stock,
  input  wire logic [gwn_pkg::RIN_W-1:0]      search_radius,
  output logic                                busy,
  output logic                                done,
  output logic                                found,
  output logic [gwn_pkg::COORD_W-1:0]         found_x,
  output logic [gwn_pkg::COORD_W-1:0]         found_y,
  output logic                                found_kind,
  output logic [gwn_pkg::OUT_DIST_W-1:0]      found_distance
);

  import gwn_pkg::*;

  ram_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  probe_t            probe;
  pick_t             pick;

  gwn_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .node_kind     (node_kind),
    .has_stock     (has_stock),
    .search_radius (search_radius),
    .busy          (busy),
    .done          (done),
    .wr            (wr),
    .rd_addr       (rd_addr),
    .probe         (probe)
  );

  gwn_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  gwn_best u_best (
    .clk        (clk),
    .rst        (rst),
    .probe      (probe),
    .cell_state (rd_data),
    .pick       (pick)
  );

  assign found          = pick.found;
  assign found_x        = pick.x;
  assign found_y        = pick.y;
  assign found_kind     = pick.kind;
  assign found_distance = pick.distance;

endmodule

`default_nettype wire

FILE: hdl/gwn_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module gwn_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/gwn_ctrl.sv
// sequencer: command decode, clearing sweep and window scan address generation
`timescale 1ns / 1ps
`default_nettype none

module gwn_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [1:0]                  command,
  input  wire logic [gwn_pkg::COORD_W-1:0] cell_x,
  input  wire logic [gwn_pkg::COORD_W-1:0] cell_y,
  input  wire logic                        node_kind,
  input  wire logic                        has_stock,
  input  wire logic [gwn_pkg::RIN_W-1:0]   search_radius,
  output logic                             busy,
  output logic                             done,
  output gwn_pkg::ram_wr_t                 wr,
  output logic [gwn_pkg::ADDR_W-1:0]       rd_addr,
  output gwn_pkg::probe_t                  probe
);

  import gwn_pkg::*;

  state_t                    state, state_next;
  logic [ADDR_W-1:0]         clr_cnt, clr_cnt_next;
  logic [COORD_W-1:0]        cx, cx_next;
  logic [COORD_W-1:0]        cy, cy_next;
  logic [RAD_W-1:0]          r, r_next;
  logic signed [RAD_W:0]     dx, dx_next;
  logic signed [RAD_W:0]     dy, dy_next;
  logic                      pr_valid, pr_valid_next;
  logic [COORD_W-1:0]        pr_x, pr_x_next;
  logic [COORD_W-1:0]        pr_y, pr_y_next;
  logic [DIST_W-1:0]         pr_dist, pr_dist_next;
  logic                      pr_clear;

  logic [RAD_W-1:0]          r_in;
  logic signed [RAD_W:0]     r_s;
  logic signed [RAD_W:0]     r_in_s;
  logic signed [POS_W-1:0]   x_pos;
  logic signed [POS_W-1:0]   y_pos;
  logic [RAD_W:0]            dx_abs;
  logic [RAD_W:0]            dy_abs;
  logic                      in_grid;
  logic                      upd_ok;

  // saturated radius of the incoming query
  assign r_in   = (int'(search_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                     : RAD_W'(search_radius);
  assign r_in_s = signed'({1'b0, r_in});
  assign r_s    = signed'({1'b0, r});

  // current probe position and distance
  assign x_pos   = POS_W'(signed'({1'b0, cx})) + POS_W'(dx);
  assign y_pos   = POS_W'(signed'({1'b0, cy})) + POS_W'(dy);
  assign in_grid = (x_pos >= 0) && (x_pos < POS_W'(GRID_SIDE)) &&
                   (y_pos >= 0) && (y_pos < POS_W'(GRID_SIDE));
  assign dx_abs  = dx[RAD_W] ? unsigned'(-dx) : unsigned'(dx);
  assign dy_abs  = dy[RAD_W] ? unsigned'(-dy) : unsigned'(dy);
  assign rd_addr = ADDR_W'(y_pos) * ADDR_W'(GRID_SIDE) + ADDR_W'(x_pos);

  assign upd_ok = (int'(cell_x) < GRID_SIDE) && (int'(cell_y) < GRID_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      pr_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      pr_valid <= pr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cx      <= cx_next;
    cy      <= cy_next;
    r       <= r_next;
    dx      <= dx_next;
    dy      <= dy_next;
    pr_x    <= pr_x_next;
    pr_y    <= pr_y_next;
    pr_dist <= pr_dist_next;
  end

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    cx_next       = cx;
    cy_next       = cy;
    r_next        = r;
    dx_next       = dx;
    dy_next       = dy;
    pr_valid_next = 1'b0;
    pr_x_next     = x_pos[COORD_W-1:0];
    pr_y_next     = y_pos[COORD_W-1:0];
    pr_dist_next  = DIST_W'(dx_abs) + DIST_W'(dy_abs);
    wr            = '0;
    busy          = (state != ST_IDLE);
    done          = 1'b0;
    pr_clear      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (command)
            CMD_CLEAR: begin
              clr_cnt_next = '0;
              state_next   = ST_CLEAR;
            end
            CMD_UPDATE: begin
              wr.en   = upd_ok;
              wr.addr = ADDR_W'(cell_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(cell_x);
              wr.data = !has_stock ? CELL_EMPTY : (node_kind ? CELL_FISH : CELL_FOOD);
            end
            CMD_QUERY: begin
              cx_next    = cell_x;
              cy_next    = cell_y;
              r_next     = r_in;
              dx_next    = -r_in_s;
              dy_next    = -r_in_s;
              pr_clear   = 1'b1;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_cnt;
        wr.data = CELL_EMPTY;
        if (clr_cnt == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      ST_SCAN: begin
        pr_valid_next = in_grid;
        if (dx == r_s) begin
          dx_next = -r_s;
          if (dy == r_s) begin
            state_next = ST_DRAIN;
          end else begin
            dy_next = dy + 1'b1;
          end
        end else begin
          dx_next = dx + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign probe.clear    = pr_clear;
  assign probe.valid    = pr_valid;
  assign probe.x        = pr_x;
  assign probe.y        = pr_y;
  assign probe.distance = pr_dist;

endmodule

`default_nettype wire

FILE: hdl/gwn_best.sv
// shared distance compare with the best fish and best food registers
`timescale 1ns / 1ps
`default_nettype none

module gwn_best (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gwn_pkg::probe_t            probe,
  input  wire logic [gwn_pkg::CELL_W-1:0] cell_state,
  output gwn_pkg::pick_t                  pick
);

  import gwn_pkg::*;

  best_t fish, food;
  best_t tgt, upd;
  logic  is_fish;
  logic  take;

  // one compare serves whichever class the cell belongs to
  assign is_fish = (cell_state == CELL_FISH);
  assign tgt     = is_fish ? fish : food;
  assign take    = probe.valid && (cell_state != CELL_EMPTY) &&
                   (!tgt.valid || (probe.distance < tgt.distance));
  assign upd     = '{valid: 1'b1, x: probe.x, y: probe.y, distance: probe.distance};

  always_ff @(posedge clk) begin
    if (rst || probe.clear) begin
      fish <= '0;
      food <= '0;
    end else if (take) begin
      if (is_fish) begin
        fish <= upd;
      end else begin
        food <= upd;
      end
    end
  end

  always_comb begin
    pick = '0;
    if (fish.valid) begin
      pick.found    = 1'b1;
      pick.x        = fish.x;
      pick.y        = fish.y;
      pick.kind     = 1'b1;
      pick.distance = OUT_DIST_W'(fish.distance);
    end else if (food.valid) begin
      pick.found    = 1'b1;
      pick.x        = food.x;
      pick.y        = food.y;
      pick.distance = OUT_DIST_W'(food.distance);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gwn_checker.sv
// port-level checks of the search core and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module gwn_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic [1:0]                     command,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic                           found,
  input wire logic [gwn_pkg::COORD_W-1:0]    found_x,
  input wire logic [gwn_pkg::COORD_W-1:0]    found_y,
  input wire logic                           found_kind,
  input wire logic [gwn_pkg::OUT_DIST_W-1:0] found_distance
);

  import gwn_pkg::*;

  // the result comes in the last busy cycle of a query
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a busy query");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |->
      (found_x == '0 && found_y == '0 && !found_kind && found_distance == '0))
    else $error("empty result carries non-zero fields");

  a_long_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_CLEAR || command == CMD_QUERY)) |=> busy)
    else $error("clear or query beat did not raise busy");

  a_update_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_UPDATE) |=> (!busy && !done))
    else $error("update beat did not finish in one cycle");

endmodule

bind grid_window_nearest_two_class_core gwn_checker u_checker (.*);

`default_nettype wire
